// ----- hdl/tgq_pkg.sv -----
// ----------------------------------------------------------------------------
// tgq_pkg
// Shared types and constants for the ticketed group queue: field widths,
// operation codes, per-cell command and status bundles, control states.
// ----------------------------------------------------------------------------
package tgq_pkg;

	// Geometry of the queue
	localparam int QUEUE_DEPTH = 16;
	localparam int TICKET_BITS = 16;
	localparam int SIZE_BITS   = 8;

	typedef logic [TICKET_BITS-1:0] ticket_t;
	typedef logic [SIZE_BITS-1:0]   size_t;

	// Operation codes
	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_SERVE   = 2'd1,
		OP_CANCEL  = 2'd2,
		OP_LOOKUP  = 2'd3
	} op_t;

	// Control states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Contents of one slot as seen by its neighbors
	typedef struct packed {
		logic    valid;
		ticket_t ticket;
		size_t   size;
	} slot_view_t;

	// Command broadcast to every cell
	typedef struct packed {
		op_t     op;
		size_t   amount;
		ticket_t ticket;
		logic    apply;
	} cell_cmd_t;

	// Per-cell status returned to the controller
	typedef struct packed {
		logic    match;
		logic    ins;
		ticket_t ins_ticket;
		logic    nxt_valid;
	} cell_stat_t;

endpackage

// ----- hdl/tgq_ifs.sv -----
// ----------------------------------------------------------------------------
// tgq_ifs
// Valid/ready channels of the ticketed group queue: request and response.
// ----------------------------------------------------------------------------
interface tgq_req_if;
	import tgq_pkg::*;

	logic    valid;
	logic    ready;
	op_t     operation;
	size_t   amount;
	ticket_t ticket;

	modport source (output valid, output operation, output amount, output ticket,
		input ready);
	modport sink (input valid, input operation, input amount, input ticket,
		output ready);
endinterface

interface tgq_rsp_if;
	import tgq_pkg::*;

	logic    valid;
	logic    ready;
	ticket_t issued_ticket;
	size_t   served_count;
	logic    found;
	logic    full_error;
	logic    queue_empty;

	modport source (output valid, output issued_ticket, output served_count,
		output found, output full_error, output queue_empty, input ready);
	modport sink (input valid, input issued_ticket, input served_count,
		input found, input full_error, input queue_empty, output ready);
endinterface

// ----- hdl/tgq_cell.sv -----
// ----------------------------------------------------------------------------
// tgq_cell
// One queue slot. Holds a group's ticket and size, compares against the
// broadcast ticket, and takes its right neighbor's contents when its own
// removal or a removal ahead of it closes the gap.
// ----------------------------------------------------------------------------
module tgq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  tgq_pkg::cell_cmd_t cmd,
	input  tgq_pkg::slot_view_t left,
	input  tgq_pkg::slot_view_t right,
	input  logic               hit_in,
	input  logic               trim,
	output tgq_pkg::slot_view_t view,
	output logic               hit_out,
	output tgq_pkg::cell_stat_t stat
);
	import tgq_pkg::*;

	logic    valid_q;
	ticket_t ticket_q;
	size_t   size_q;

	logic    match;
	logic    first;
	logic    shift;
	logic    ins;
	ticket_t ins_ticket;

	// Compare, first-match and insert-point detection
	always_comb begin
		match      = valid_q && (ticket_q == cmd.ticket);
		first      = (cmd.op == OP_CANCEL) && match && !hit_in;
		shift      = hit_in || first;
		ins        = (cmd.op == OP_ENQUEUE) && !valid_q && left.valid;
		ins_ticket = left.ticket + ticket_t'(1);
	end

	assign hit_out = shift;
	assign view    = '{valid: valid_q, ticket: ticket_q, size: size_q};

	always_comb begin
		stat.match      = match;
		stat.ins        = ins;
		stat.ins_ticket = ins_ticket;
		if (shift) begin
			stat.nxt_valid = right.valid;
		end else if (ins) begin
			stat.nxt_valid = 1'b1;
		end else begin
			stat.nxt_valid = valid_q;
		end
	end

	// Occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.apply) begin
			valid_q <= stat.nxt_valid;
		end
	end

	// Slot payload: shift in, append, or trim at the head
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			if (shift) begin
				ticket_q <= right.ticket;
				size_q   <= right.size;
			end else if (ins) begin
				ticket_q <= ins_ticket;
				size_q   <= cmd.amount;
			end else if (trim) begin
				size_q   <= size_q - cmd.amount;
			end
		end
	end

endmodule

// ----- hdl/ticketed_group_queue_core.sv -----
// ----------------------------------------------------------------------------
// ticketed_group_queue_core
// Ordered queue of ticketed groups built as a row of slot cells. Supports
// enqueue, serve, cancel by ticket and lookup; one response per request.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  --------+-----+--------------------------------------------------------
//  req     | in  | operation, amount, ticket
//  rsp     | out | issued_ticket, served_count, found, full_error, queue_empty
//
// Each request is first registered; in the execute state all cells then
// compare in parallel and shift or append at the closing edge.
// The ripple of the first-match chain across the cells sets the cycle length.
// A pending response does not block acceptance of the next request; the cell
// update waits while the response register is still occupied.
// Reset clears all slot valid flags and the control state.
// ----------------------------------------------------------------------------
module ticketed_group_queue_core (
	input  logic      clk,
	input  logic      arst_n,
	tgq_req_if.sink   req,
	tgq_rsp_if.source rsp
);
	import tgq_pkg::*;

	localparam int LastCell = QUEUE_DEPTH - 1;

	state_t  state_q, state_d;
	op_t     op_q;
	size_t   amount_q;
	ticket_t ticket_q;

	logic    rsp_valid_q;
	ticket_t issued_q;
	size_t   served_q;
	logic    found_q;
	logic    full_q;
	logic    empty_q;

	logic    apply;
	cell_cmd_t  cmd;
	slot_view_t view  [QUEUE_DEPTH];
	cell_stat_t stat  [QUEUE_DEPTH];
	logic       hit   [QUEUE_DEPTH+1];

	logic    head_fits;
	logic    serve_remove;
	logic    serve_trim;
	ticket_t issued_d;
	size_t   served_d;
	logic    any_match;

	// Control state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		apply     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				apply = !rsp_valid_q || rsp.ready;
				if (apply) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q     <= req.operation;
			amount_q <= req.amount;
			ticket_q <= req.ticket;
		end
	end

	assign cmd = '{op: op_q, amount: amount_q, ticket: ticket_q, apply: apply};

	// Head decisions for serve
	assign head_fits    = view[0].size <= amount_q;
	assign serve_remove = (op_q == OP_SERVE) && view[0].valid && head_fits;
	assign serve_trim   = (op_q == OP_SERVE) && view[0].valid && !head_fits;
	assign hit[0]       = serve_remove;

	// Row of slot cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		slot_view_t left_v;
		slot_view_t right_v;

		if (i == 0) begin : g_head
			assign left_v = '{valid: 1'b1, ticket: '0, size: '0};
		end else begin : g_body
			assign left_v = view[i-1];
		end

		if (i == LastCell) begin : g_tail
			assign right_v = '{valid: 1'b0, ticket: '0, size: '0};
		end else begin : g_inner
			assign right_v = view[i+1];
		end

		tgq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.left    (left_v),
			.right   (right_v),
			.hit_in  (hit[i]),
			.trim    ((i == 0) ? serve_trim : 1'b0),
			.view    (view[i]),
			.hit_out (hit[i+1]),
			.stat    (stat[i])
		);
	end

	// Gather cell status
	always_comb begin
		issued_d  = '0;
		any_match = 1'b0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (stat[i].ins) begin
				issued_d = issued_d | stat[i].ins_ticket;
			end
			any_match = any_match | stat[i].match;
		end
		served_d = '0;
		if (op_q == OP_SERVE && view[0].valid) begin
			served_d = head_fits ? view[0].size : amount_q;
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (apply) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			issued_q <= issued_d;
			served_q <= served_d;
			found_q  <= ((op_q == OP_CANCEL) || (op_q == OP_LOOKUP)) && any_match;
			full_q   <= (op_q == OP_ENQUEUE) && view[LastCell].valid;
			empty_q  <= !stat[0].nxt_valid;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.issued_ticket = issued_q;
	assign rsp.served_count  = served_q;
	assign rsp.found         = found_q;
	assign rsp.full_error    = full_q;
	assign rsp.queue_empty   = empty_q;

endmodule

// ----- hdl/tgq_checker.sv -----
// ----------------------------------------------------------------------------
// tgq_checker
// Port-level checks on the ticketed group queue's response channel.
// ----------------------------------------------------------------------------
module tgq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input tgq_pkg::ticket_t  issued_ticket,
	input tgq_pkg::size_t    served_count,
	input logic              found,
	input logic              full_error,
	input logic              queue_empty
);
	import tgq_pkg::*;

	// Stalled response holds its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(issued_ticket)
		&& $stable(served_count) && $stable(found) && $stable(full_error)
		&& $stable(queue_empty))
		else $error("response changed while stalled");

	// A dropped enqueue issues no ticket, finds no match and leaves a full, hence non-empty, queue
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && full_error |-> issued_ticket == '0 && !queue_empty && !found)
		else $error("full error with ticket, match or empty queue");

	// Serving people excludes the other operations' results
	a_serve_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && served_count != '0 |-> issued_ticket == '0 && !found && !full_error)
		else $error("serve result mixed with other operation results");

	// An issued ticket means a group is now queued
	a_issue_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && issued_ticket != '0 |-> !queue_empty && !found)
		else $error("ticket issued but queue reported empty");

endmodule

bind ticketed_group_queue_core tgq_checker u_tgq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.issued_ticket (rsp.issued_ticket),
	.served_count  (rsp.served_count),
	.found         (rsp.found),
	.full_error    (rsp.full_error),
	.queue_empty   (rsp.queue_empty)
);

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ticketed_group_queue_core. A tracker class keeps a
// copy of the queue, predicts each response when its request is accepted and
// checks responses in order. Stimulus: a directed opening (empty queue, zero
// and maximum sizes, shrink, full queue, cancel and lookup), a random mix
// with idle gaps on both channels, then a short closing run that trims the
// queue down to its head and works on the head group.
// ----------------------------------------------------------------------------
module tb;
	import tgq_pkg::*;

	// One response as predicted
	typedef struct {
		ticket_t issued;
		size_t   served;
		logic    found;
		logic    full;
		logic    empty;
	} outcome_t;

	// Queue tracker: own copy of the slots, expected responses in order
	class ticket_queue_tracker;
		ticket_t  slot_tk [QUEUE_DEPTH];
		size_t    slot_sz [QUEUE_DEPTH];
		int       groups;
		int       errors;
		outcome_t pending_outcomes [$];

		function new();
			groups = 0;
			errors = 0;
		endfunction

		// Remove a group and close the gap toward the head
		function void drop(int pos);
			for (int i = pos; i + 1 < groups; i++) begin
				slot_tk[i] = slot_tk[i+1];
				slot_sz[i] = slot_sz[i+1];
			end
			groups--;
		endfunction

		// Apply an accepted request to the copy and queue its response
		function void book_request(op_t op, size_t amt, ticket_t tk);
			outcome_t o;
			int       pos;
			o   = '{issued: '0, served: '0, found: 1'b0, full: 1'b0, empty: 1'b0};
			pos = -1;
			case (op)
				OP_ENQUEUE: begin
					if (groups >= QUEUE_DEPTH) begin
						o.full = 1'b1;
					end else begin
						o.issued = (groups == 0) ? ticket_t'(1) :
							ticket_t'(slot_tk[groups-1] + 1'b1);
						slot_tk[groups] = o.issued;
						slot_sz[groups] = amt;
						groups++;
					end
				end
				OP_SERVE: begin
					if (groups != 0) begin
						if (slot_sz[0] <= amt) begin
							o.served = slot_sz[0];
							drop(0);
						end else begin
							o.served   = amt;
							slot_sz[0] = slot_sz[0] - amt;
						end
					end
				end
				default: begin
					// first match counted from the head
					for (int i = groups - 1; i >= 0; i--)
						if (slot_tk[i] == tk) pos = i;
					if (pos >= 0) begin
						o.found = 1'b1;
						if (op == OP_CANCEL) drop(pos);
					end
				end
			endcase
			o.empty = (groups == 0);
			pending_outcomes.push_back(o);
		endfunction

		task report(string msg);
			$display("%0t ns: %s", $time, msg);
			errors++;
		endtask

		// Compare one response transfer with the oldest prediction
		task match_response(ticket_t issued, size_t served, logic found, logic full,
				logic empty);
			outcome_t w;
			if (pending_outcomes.size() == 0) begin
				report("response with no request outstanding");
				return;
			end
			w = pending_outcomes.pop_front();
			if (issued !== w.issued)
				report($sformatf("issued_ticket %h, want %h", issued, w.issued));
			if (served !== w.served)
				report($sformatf("served_count %h, want %h", served, w.served));
			if (found !== w.found)
				report($sformatf("found %b, want %b", found, w.found));
			if (full !== w.full)
				report($sformatf("full_error %b, want %b", full, w.full));
			if (empty !== w.empty)
				report($sformatf("queue_empty %b, want %b", empty, w.empty));
		endtask

		function int pending();
			return pending_outcomes.size();
		endfunction

		function int occupancy();
			return groups;
		endfunction

		function ticket_t head_ticket();
			return slot_tk[0];
		endfunction

		function ticket_t tail_ticket();
			return slot_tk[groups-1];
		endfunction

		// Mostly a ticket that is present, sometimes any ticket
		function ticket_t pick_ticket();
			if (groups == 0 || $urandom_range(3) == 0)
				return ticket_t'($urandom);
			return slot_tk[$urandom_range(groups - 1)];
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   max_idle;

	tgq_req_if req_ch ();
	tgq_rsp_if rsp_ch ();

	ticket_queue_tracker sb = new();

	ticketed_group_queue_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Overall time limit
	initial begin
		#200ms;
		$display("[ticketed_group_queue_core] ERROR");
		$finish;
	end

	// Drive one request and hold it until the transfer
	task automatic send_request(op_t op, size_t amt, ticket_t tk);
		int gap;
		gap = $urandom_range(max_idle);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.operation <= op;
		req_ch.amount    <= amt;
		req_ch.ticket    <= tk;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		sb.book_request(op, amt, tk);
	endtask

	function automatic size_t pick_amount(op_t op);
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return (op == OP_SERVE) ? size_t'($urandom_range(40)) : size_t'($urandom);
			default: return size_t'($urandom);
		endcase
	endfunction

	// Response side: random stalls, check every transfer
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = $urandom_range(max_idle);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_ch.valid) @(posedge clk);
			sb.match_response(rsp_ch.issued_ticket, rsp_ch.served_count, rsp_ch.found,
				rsp_ch.full_error, rsp_ch.queue_empty);
		end
	end

	// Main sequence
	initial begin
		int      enq_weight;
		int      r;
		op_t     op;
		max_idle         = 6;
		enq_weight       = 40;
		arst_n           = 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.operation <= OP_ENQUEUE;
		req_ch.amount    <= '0;
		req_ch.ticket    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty queue, zero-size group, shrink, full queue
		send_request(OP_SERVE, '1, '0);
		send_request(OP_CANCEL, 8'h5a, '1);
		send_request(OP_ENQUEUE, '0, '0);
		send_request(OP_ENQUEUE, '1, '0);
		send_request(OP_SERVE, '0, '0);
		send_request(OP_SERVE, 8'd100, '0);
		for (int i = 0; i < QUEUE_DEPTH - 1; i++)
			send_request(OP_ENQUEUE, size_t'(i * 17), '0);
		send_request(OP_ENQUEUE, 8'd7, '0);
		send_request(OP_LOOKUP, '0, ticket_t'(9));
		send_request(OP_CANCEL, '0, ticket_t'(9));
		send_request(OP_CANCEL, '0, ticket_t'(17));
		send_request(OP_LOOKUP, '1, ticket_t'(9));

		// Random mix; idle level and enqueue share change per chunk
		for (int n = 0; n < 1750; n++) begin
			if (n % 100 == 0) begin
				max_idle   = ($urandom_range(3) == 0) ? 0 : 6;
				enq_weight = $urandom_range(65, 20);
			end
			if ($urandom_range(99) < enq_weight) begin
				op = OP_ENQUEUE;
			end else begin
				r = $urandom_range(4);
				if (r < 3)
					op = OP_SERVE;
				else if (r == 3)
					op = OP_CANCEL;
				else
					op = OP_LOOKUP;
			end
			send_request(op, pick_amount(op), sb.pick_ticket());
		end

		// Trim down to the head group, then append one behind it
		max_idle = 0;
		while (sb.occupancy() > 1)
			send_request(OP_CANCEL, size_t'($urandom), sb.tail_ticket());
		if (sb.occupancy() == 0)
			send_request(OP_ENQUEUE, size_t'($urandom), '0);
		send_request(OP_ENQUEUE, size_t'($urandom), '0);

		// Lookup and cancel at the head
		max_idle = 6;
		send_request(OP_LOOKUP, '0, sb.head_ticket());
		send_request(OP_CANCEL, '0, sb.head_ticket());
		send_request(OP_LOOKUP, '0, sb.head_ticket());
		send_request(OP_SERVE, '1, '0);
		req_ch.valid <= 1'b0;

		// Drain, then watch for stray responses
		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("[ticketed_group_queue_core] OK");
		else
			$display("[ticketed_group_queue_core] ERROR");
		$finish;
	end
endmodule
